// ===== hw/rtl/dtp_pkg.sv =====
// dtp_pkg: shared types, constants and unit table for the duration text parser
`timescale 1ns / 1ps
package dtp_pkg;

	localparam int TOTAL_WIDTH_DEF = 48;
	localparam int OUT_TOTAL_W     = 48;
	localparam int CHAR_W          = 8;
	localparam int COUNT_W         = 20;
	localparam int PROD_W          = 40;
	localparam int M_TDATA_W       = 56;
	localparam logic [COUNT_W-1:0] COUNT_LIMIT = 20'd1000000;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [COUNT_W-1:0] WORTH_S = 20'd1;
	localparam logic [COUNT_W-1:0] WORTH_M = 20'd60;
	localparam logic [COUNT_W-1:0] WORTH_H = 20'(60 * 60);
	localparam logic [COUNT_W-1:0] WORTH_D = 20'(24 * 60 * 60);
	localparam logic [COUNT_W-1:0] WORTH_W = 20'(7 * 24 * 60 * 60);

	typedef enum logic [1:0] {
		CL_SPACE,
		CL_DIGIT,
		CL_UNIT,
		CL_OTHER
	} char_class_t;

	typedef enum logic [2:0] {
		UNIT_S,
		UNIT_M,
		UNIT_H,
		UNIT_D,
		UNIT_W
	} unit_t;

	typedef enum logic [1:0] {
		PH_BETWEEN,
		PH_DIGITS,
		PH_FAILED
	} phase_t;

	// one classified character word
	typedef struct packed {
		char_class_t cls;
		logic [3:0]  digit;
		unit_t       unit;
		logic        last;
	} token_t;

	function automatic logic [COUNT_W-1:0] unit_worth(input unit_t u);
		logic [COUNT_W-1:0] w;
		case (u)
			UNIT_S:  w = WORTH_S;
			UNIT_M:  w = WORTH_M;
			UNIT_H:  w = WORTH_H;
			UNIT_D:  w = WORTH_D;
			UNIT_W:  w = WORTH_W;
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

// ===== hw/rtl/dtp_front.sv =====
// dtp_front: character classifier that turns ascii codes into token words
`timescale 1ns / 1ps
module dtp_front (
	input  logic [dtp_pkg::CHAR_W-1:0] char_code,
	input  logic                       last_char,
	output dtp_pkg::token_t            token
);
	import dtp_pkg::*;

	logic [CHAR_W-1:0] lower;

	assign lower = char_code | 8'h20;

	always_comb begin
		token.last  = last_char;
		token.digit = 4'(char_code - 8'h30);
		token.unit  = UNIT_S;
		token.cls   = CL_OTHER;
		if (char_code inside {[8'h30:8'h39]}) begin
			token.cls = CL_DIGIT;
		end else if (char_code == 8'h20 || char_code inside {[8'h09:8'h0D]}) begin
			token.cls = CL_SPACE;
		end else begin
			case (lower)
				8'h73: begin token.cls = CL_UNIT; token.unit = UNIT_S; end
				8'h6D: begin token.cls = CL_UNIT; token.unit = UNIT_M; end
				8'h68: begin token.cls = CL_UNIT; token.unit = UNIT_H; end
				8'h64: begin token.cls = CL_UNIT; token.unit = UNIT_D; end
				8'h77: begin token.cls = CL_UNIT; token.unit = UNIT_W; end
				default: token.cls = CL_OTHER;
			endcase
		end
	end

endmodule

// ===== hw/rtl/dtp_queue.sv =====
// dtp_queue: short fifo of token words between classifier and executor
`timescale 1ns / 1ps
module dtp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dtp_pkg::token_t push_word,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output dtp_pkg::token_t pop_word
);
	import dtp_pkg::*;

	token_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	assign full     = (fill_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty    = (fill_q == '0);
	assign pop_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push && !full, pop && !empty})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/dtp_back.sv =====
// dtp_back: token parser, unit multiply and saturating accumulate with output register
`timescale 1ns / 1ps
module dtp_back #(
	parameter int TOTAL_WIDTH = dtp_pkg::TOTAL_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  dtp_pkg::token_t                 in_word,
	output logic                            in_pop,
	output logic                            res_valid,
	input  logic                            res_ready,
	output logic                            res_ok,
	output logic [dtp_pkg::OUT_TOTAL_W-1:0] res_total
);
	import dtp_pkg::*;

	logic adv;

	// parser state
	phase_t             phase_q, phase_next;
	logic [COUNT_W-1:0] count_q, count_next;
	logic               add_now;
	logic [23:0]        count_x10;

	// stage 1: parse result
	logic               valid_s1, add_s1, last_s1, endok_s1;
	logic [COUNT_W-1:0] count_s1;
	unit_t              unit_s1;

	// stage 2: product
	logic               valid_s2, add_s2, last_s2, endok_s2;
	logic [PROD_W-1:0]  prod_s2;

	// accumulator
	logic [TOTAL_WIDTH-1:0] total_q;
	logic [TOTAL_WIDTH:0]   sum_wide;
	logic [TOTAL_WIDTH-1:0] sum_new;
	logic [63:0]            sum_ext;
	logic                   ok_now;

	assign adv    = !res_valid || res_ready;
	assign in_pop = adv && in_valid;

	assign count_x10 = 24'({count_q, 3'b000}) + 24'({count_q, 1'b0}) + 24'(in_word.digit);

	always_comb begin
		phase_next = phase_q;
		count_next = count_q;
		case (phase_q)
			PH_BETWEEN: begin
				case (in_word.cls)
					CL_SPACE: phase_next = PH_BETWEEN;
					CL_DIGIT: begin
						phase_next = PH_DIGITS;
						count_next = COUNT_W'(in_word.digit);
					end
					default: phase_next = PH_FAILED;
				endcase
			end
			PH_DIGITS: begin
				case (in_word.cls)
					CL_DIGIT: begin
						if (count_x10 > 24'(COUNT_LIMIT)) begin
							phase_next = PH_FAILED;
						end else begin
							count_next = count_x10[COUNT_W-1:0];
						end
					end
					CL_UNIT: begin
						phase_next = PH_BETWEEN;
						count_next = '0;
					end
					default: phase_next = PH_FAILED;
				endcase
			end
			default: phase_next = PH_FAILED;
		endcase
	end

	// a unit letter right after digits closes the token
	always_comb begin
		add_now = 1'b0;
		if (phase_q == PH_DIGITS && in_word.cls == CL_UNIT) begin
			add_now = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_BETWEEN;
			count_q  <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			if (in_valid) begin
				if (in_word.last) begin
					phase_q <= PH_BETWEEN;
					count_q <= '0;
				end else begin
					phase_q <= phase_next;
					count_q <= count_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			add_s1   <= add_now;
			last_s1  <= in_word.last;
			endok_s1 <= (phase_next == PH_BETWEEN);
			count_s1 <= count_q;
			unit_s1  <= in_word.unit;
			add_s2   <= add_s1;
			last_s2  <= last_s1;
			endok_s2 <= endok_s1;
			prod_s2  <= PROD_W'(count_s1) * PROD_W'(unit_worth(unit_s1));
		end
	end

	assign sum_wide = {1'b0, total_q} + (TOTAL_WIDTH+1)'(prod_s2);
	assign sum_new  = !add_s2 ? total_q :
		(sum_wide[TOTAL_WIDTH] ? {TOTAL_WIDTH{1'b1}} : sum_wide[TOTAL_WIDTH-1:0]);
	assign sum_ext  = 64'(sum_new);
	assign ok_now   = endok_s2 && (sum_new != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= valid_s2 && last_s2;
			if (valid_s2) begin
				total_q <= last_s2 ? '0 : sum_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2 && last_s2) begin
			res_ok <= ok_now;
			if (!ok_now) begin
				res_total <= '0;
			end else if (|sum_ext[63:OUT_TOTAL_W]) begin
				res_total <= '1;
			end else begin
				res_total <= sum_ext[OUT_TOTAL_W-1:0];
			end
		end
	end

endmodule

// ===== hw/rtl/duration_text_parser.sv =====
// duration_text_parser: top level of the streaming duration text parser
`timescale 1ns / 1ps
// takes a duration text such as "1d 2h30m" one ascii character per word on the
// slave stream, s_tlast on the final character. tokens are decimal counts (up to
// 1000000) followed by a unit s/m/h/d/w in either case; whitespace between tokens
// is skipped. on the last character one result word leaves on the master stream:
// ok and the saturated total in seconds (zero when not ok). a character is taken
// every cycle while the queue has room; the classifier feeds a four word queue,
// and the executor runs a two stage pipe (parse, unit multiply) and then
// accumulates into the total and the output register together, so the last
// character passes from the queue through the parse and product registers into
// the output register. a stalled result word holds the whole executor; the queue
// then fills within four more words and s_tready drops.
module duration_text_parser #(
	parameter int TOTAL_WIDTH = dtp_pkg::TOTAL_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input characters
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [dtp_pkg::CHAR_W-1:0]    s_tdata,  // [7:0] char_code
	input  logic                          s_tlast,  // last_char
	// results
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [dtp_pkg::M_TDATA_W-1:0] m_tdata   // [0] ok, [48:1] total_seconds
);
	import dtp_pkg::*;

	token_t               front_word;
	token_t               queue_word;
	logic                 queue_full;
	logic                 queue_empty;
	logic                 back_pop;
	logic                 res_ok;
	logic [OUT_TOTAL_W-1:0] res_total;

	// classify each character as it arrives
	dtp_front u_front (
		.char_code (s_tdata),
		.last_char (s_tlast),
		.token     (front_word)
	);

	// decouple intake from the executor pipe
	dtp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid),
		.push_word (front_word),
		.full      (queue_full),
		.pop       (back_pop),
		.empty     (queue_empty),
		.pop_word  (queue_word)
	);

	assign s_tready = !queue_full;

	// parse tokens, multiply by unit worth, accumulate, register result
	dtp_back #(
		.TOTAL_WIDTH (TOTAL_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (!queue_empty),
		.in_word   (queue_word),
		.in_pop    (back_pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_ok    (res_ok),
		.res_total (res_total)
	);

	// pack result word, zero fill to whole bytes
	assign m_tdata = {{(M_TDATA_W - OUT_TOTAL_W - 1){1'b0}}, res_total, res_ok};

endmodule
